[design/tdpc_pkg.sv]
// Shared types and constants for the trigger debounce / press classifier.
// Holds event codes, source mode codes, register indexes and reset values.
// No dependencies.
package tdpc_pkg;

  localparam int unsigned TickW     = 32;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned DebW      = 16;
  localparam int unsigned LongW     = 24;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_BUTTON   = 3'd1,
    EV_TOUCH    = 3'd2,
    EV_WAKE     = 3'd3,
    EV_RECONFIG = 3'd4
  } event_e;

  // Source modes; every code above MODE_BTN_WAKE means no source.
  localparam logic [ModeW-1:0] MODE_BUTTON   = 3'd0;
  localparam logic [ModeW-1:0] MODE_TOUCH    = 3'd1;
  localparam logic [ModeW-1:0] MODE_WAKE     = 3'd2;
  localparam logic [ModeW-1:0] MODE_BTN_WAKE = 3'd3;

  // Register indexes on the write port
  localparam logic [CfgIdxW-1:0] CFG_SOURCE_MODE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BUTTON_LEVEL = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RC_LEVEL     = 3'd4;

  localparam logic [ModeW-1:0] ModeRst     = MODE_BUTTON;
  localparam logic [DebW-1:0]  DebounceRst = 16'd5;
  localparam logic [LongW-1:0] LongRst     = 24'd300;

endpackage

[design/trigger_debounce_press_classifier.sv]
// Top level of the trigger debounce / press classifier.
// Depends on tdpc_pkg for event codes, mode codes and register indexes.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one timer tick per word:
//   raw levels of the main and reconfig buttons, the wake detect pulse, the
//   wake accept flag and touch presence with its coordinates. Every accepted
//   word produces exactly one result word on the output channel
//   (out_valid_o / out_stall_i): an event code and, for touch events, the
//   touch point. Event code 0 means no event on that tick.
//   The result is registered: it is in the output register in the cycle
//   after acceptance. Throughput is one word per cycle unless the receiver
//   stalls; the debounce and press-time checks are four 32-bit subtracts
//   and four compares in one stage. When the receiver stalls, the result
//   holds in the output register and the input is stalled only while that
//   result waits; as soon as it is taken a new word can enter in the same cycle.
//   Reset clears all tick state and loads register defaults (mode button,
//   debounce 5, long press 300, both active levels low). The first word after
//   reset, or any word in mode none, only loads the sampled levels.
//   Registers are written through cfg_we_i / cfg_index_i / cfg_data_i; the user
//   must write them only while the block is idle; the block does not enforce it.
module trigger_debounce_press_classifier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tdpc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [tdpc_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               button_level_i,
  input  logic                               reconfig_level_i,
  input  logic                               wake_detect_i,
  input  logic                               accepting_i,
  input  logic                               touch_present_i,
  input  logic [tdpc_pkg::CoordW-1:0]        touch_x_in_i,
  input  logic [tdpc_pkg::CoordW-1:0]        touch_y_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         event_code_o,
  output logic [tdpc_pkg::CoordW-1:0]        event_x_o,
  output logic [tdpc_pkg::CoordW-1:0]        event_y_o
);

  localparam int unsigned TW = tdpc_pkg::TickW;

  // Configuration registers
  logic [tdpc_pkg::ModeW-1:0] mode_q;
  logic [tdpc_pkg::DebW-1:0]  deb_q;
  logic [tdpc_pkg::LongW-1:0] long_q;
  logic                       btn_act_q;
  logic                       rc_act_q;

  // Tick state
  logic          started_q, started_d;
  logic [TW-1:0] tick_q, tick_d;
  logic          main_last_q, main_last_d;
  logic          main_stable_q, main_stable_d;
  logic [TW-1:0] main_chg_q, main_chg_d;
  logic [TW-1:0] main_start_q, main_start_d;
  logic          main_press_q, main_press_d;
  logic          rc_last_q, rc_last_d;
  logic          rc_stable_q, rc_stable_d;
  logic [TW-1:0] rc_chg_q, rc_chg_d;
  logic [TW-1:0] rc_start_q, rc_start_d;
  logic          rc_press_q, rc_press_d;
  logic          rc_long_q, rc_long_d;
  logic          touch_was_q, touch_was_d;

  // Output register
  logic                          out_valid_q;
  tdpc_pkg::event_e              code_q, code_d;
  logic [tdpc_pkg::CoordW-1:0]   ex_q, ex_d, ey_q, ey_d;

  logic          in_accept;
  logic [TW-1:0] rc_elapsed, rc_held, main_elapsed, main_held;
  logic          rc_settled, rc_long_hit, main_settled, main_short;
  logic          wake_on, button_on;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign rc_elapsed   = tick_q - rc_chg_q;
  assign rc_held      = tick_q - rc_start_q;
  assign main_elapsed = tick_q - main_chg_q;
  assign main_held    = tick_q - main_start_q;
  assign rc_settled   = rc_elapsed >= {{(TW-tdpc_pkg::DebW){1'b0}}, deb_q};
  assign main_settled = main_elapsed >= {{(TW-tdpc_pkg::DebW){1'b0}}, deb_q};
  assign rc_long_hit  = rc_held >= {{(TW-tdpc_pkg::LongW){1'b0}}, long_q};
  assign main_short   = main_held < {{(TW-tdpc_pkg::LongW){1'b0}}, long_q};

  assign wake_on   = (mode_q == tdpc_pkg::MODE_WAKE) || (mode_q == tdpc_pkg::MODE_BTN_WAKE);
  assign button_on = (mode_q == tdpc_pkg::MODE_BUTTON) ||
                     (mode_q == tdpc_pkg::MODE_BTN_WAKE);

  always_comb begin
    started_d     = started_q;
    tick_d        = tick_q + {{(TW-1){1'b0}}, 1'b1};
    main_last_d   = main_last_q;
    main_stable_d = main_stable_q;
    main_chg_d    = main_chg_q;
    main_start_d  = main_start_q;
    main_press_d  = main_press_q;
    rc_last_d     = rc_last_q;
    rc_stable_d   = rc_stable_q;
    rc_chg_d      = rc_chg_q;
    rc_start_d    = rc_start_q;
    rc_press_d    = rc_press_q;
    rc_long_d     = rc_long_q;
    touch_was_d   = touch_was_q;
    code_d        = tdpc_pkg::EV_NONE;
    ex_d          = '0;
    ey_d          = '0;

    if ((mode_q > tdpc_pkg::MODE_BTN_WAKE) || !started_q) begin
      // Reload sampled levels; mode none stays unstarted
      started_d     = (mode_q <= tdpc_pkg::MODE_BTN_WAKE);
      main_last_d   = button_level_i;
      main_stable_d = button_level_i;
      main_chg_d    = tick_q;
      main_start_d  = '0;
      main_press_d  = 1'b0;
      rc_last_d     = reconfig_level_i;
      rc_stable_d   = reconfig_level_i;
      rc_chg_d      = tick_q;
      rc_start_d    = '0;
      rc_press_d    = 1'b0;
      rc_long_d     = 1'b0;
      touch_was_d   = 1'b0;
    end else begin
      // Reconfig button, always polled
      if (reconfig_level_i != rc_last_q) begin
        rc_last_d = reconfig_level_i;
        rc_chg_d  = tick_q;
      end else if (rc_settled) begin
        if (rc_stable_q == reconfig_level_i) begin
          if ((reconfig_level_i == rc_act_q) && rc_press_q && !rc_long_q && rc_long_hit) begin
            rc_long_d = 1'b1;
            code_d    = tdpc_pkg::EV_RECONFIG;
          end
        end else begin
          rc_stable_d = reconfig_level_i;
          if (reconfig_level_i == rc_act_q) begin
            rc_press_d = 1'b1;
            rc_start_d = tick_q;
            rc_long_d  = 1'b0;
          end else if (rc_press_q) begin
            rc_press_d = 1'b0;
            rc_start_d = '0;
            rc_long_d  = 1'b0;
          end
        end
      end

      // Lower sources only when reconfig did not fire
      if (code_d == tdpc_pkg::EV_NONE) begin
        if (wake_on && accepting_i && wake_detect_i) begin
          code_d = tdpc_pkg::EV_WAKE;
        end else if (mode_q == tdpc_pkg::MODE_TOUCH) begin
          if (touch_present_i && !touch_was_q) begin
            touch_was_d = 1'b1;
            code_d      = tdpc_pkg::EV_TOUCH;
            ex_d        = touch_x_in_i;
            ey_d        = touch_y_in_i;
          end else begin
            touch_was_d = touch_present_i;
          end
        end else if (button_on) begin
          if (button_level_i != main_last_q) begin
            main_last_d = button_level_i;
            main_chg_d  = tick_q;
          end else if (main_settled && (main_stable_q != button_level_i)) begin
            main_stable_d = button_level_i;
            if (button_level_i == btn_act_q) begin
              main_press_d = 1'b1;
              main_start_d = tick_q;
            end else if (main_press_q) begin
              main_press_d = 1'b0;
              main_start_d = '0;
              // Release after a long hold raises nothing
              if (main_short) begin
                code_d = tdpc_pkg::EV_BUTTON;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= tdpc_pkg::ModeRst;
      deb_q     <= tdpc_pkg::DebounceRst;
      long_q    <= tdpc_pkg::LongRst;
      btn_act_q <= 1'b0;
      rc_act_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tdpc_pkg::CFG_SOURCE_MODE:  mode_q    <= cfg_data_i[tdpc_pkg::ModeW-1:0];
        tdpc_pkg::CFG_DEBOUNCE:     deb_q     <= cfg_data_i[tdpc_pkg::DebW-1:0];
        tdpc_pkg::CFG_LONG_PRESS:   long_q    <= cfg_data_i[tdpc_pkg::LongW-1:0];
        tdpc_pkg::CFG_BUTTON_LEVEL: btn_act_q <= cfg_data_i[0];
        tdpc_pkg::CFG_RC_LEVEL:     rc_act_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      tick_q        <= '0;
      main_last_q   <= 1'b0;
      main_stable_q <= 1'b0;
      main_chg_q    <= '0;
      main_start_q  <= '0;
      main_press_q  <= 1'b0;
      rc_last_q     <= 1'b0;
      rc_stable_q   <= 1'b0;
      rc_chg_q      <= '0;
      rc_start_q    <= '0;
      rc_press_q    <= 1'b0;
      rc_long_q     <= 1'b0;
      touch_was_q   <= 1'b0;
    end else if (in_accept) begin
      started_q     <= started_d;
      tick_q        <= tick_d;
      main_last_q   <= main_last_d;
      main_stable_q <= main_stable_d;
      main_chg_q    <= main_chg_d;
      main_start_q  <= main_start_d;
      main_press_q  <= main_press_d;
      rc_last_q     <= rc_last_d;
      rc_stable_q   <= rc_stable_d;
      rc_chg_q      <= rc_chg_d;
      rc_start_q    <= rc_start_d;
      rc_press_q    <= rc_press_d;
      rc_long_q     <= rc_long_d;
      touch_was_q   <= touch_was_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      code_q <= code_d;
      ex_q   <= ex_d;
      ey_q   <= ey_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = code_q;
  assign event_x_o    = ex_q;
  assign event_y_o    = ey_q;

  // Every accepted word leaves a result in the output register
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted word produced no result");

  // Coordinates are zero on anything but a touch event
  a_coord_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (event_code_o != tdpc_pkg::EV_TOUCH)) |->
      ((event_x_o == '0) && (event_y_o == '0)))
    else $error("non-touch event carries coordinates");

  // A reconfig event marks the long press as reported
  a_rc_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (code_d == tdpc_pkg::EV_RECONFIG)) |=> (rc_long_q && rc_press_q))
    else $error("reconfig event without reported long press");

  // Tick advances by exactly one per accepted word
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (tick_q == ($past(tick_q) + {{(TW-1){1'b0}}, 1'b1})))
    else $error("tick did not advance by one");

endmodule
